>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the radix conversion block.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define AST_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a consequent holds in the cycle after an antecedent.
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/rcvs_pkg.sv
// Package of the radix conversion block: transaction structs, field widths
// and the digit character table. Depends on nothing.
`default_nettype none

package rcvs_pkg;

	localparam int NUMBER_W = 31;
	localparam int BASE_W   = 5;
	localparam int DIGIT_W  = 4;
	localparam int CHAR_W   = 7;
	localparam int BITCNT_W = $clog2(NUMBER_W);

	localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

	typedef struct packed {
		logic [NUMBER_W-1:0] number;
		logic [BASE_W-1:0]   base;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
	} result_t;

	// Digit value to ASCII: 0-9 then A-F.
	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		case (d)
			4'd0:    c = 7'h30;
			4'd1:    c = 7'h31;
			4'd2:    c = 7'h32;
			4'd3:    c = 7'h33;
			4'd4:    c = 7'h34;
			4'd5:    c = 7'h35;
			4'd6:    c = 7'h36;
			4'd7:    c = 7'h37;
			4'd8:    c = 7'h38;
			4'd9:    c = 7'h39;
			4'd10:   c = 7'h41;
			4'd11:   c = 7'h42;
			4'd12:   c = 7'h43;
			4'd13:   c = 7'h44;
			4'd14:   c = 7'h45;
			4'd15:   c = 7'h46;
			default: c = 7'h30;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/radix_convert_via_stack_unit.sv
// Top level of the radix conversion block: divider, digit stack and sequencer.
// Depends on rcvs_pkg and assert_macros.svh.
`default_nettype none

// Converts a non-negative 31-bit number into its digit string in a base from
// 2 to 16 and emits one ASCII character per result, most significant first.
//
// Input: a transaction is taken at a rising edge with start high and busy low.
// item.base is clamped into 2..16. A zero number is taken and gives no result;
// busy does not rise for it.
// Output: each character stands on result for one cycle with result_valid
// high; result.last_digit marks the final (least significant) character. The
// receiver cannot stall the block, so no result is ever held back.
// Operation: one shared 5-bit subtract/compare unit runs a restoring division of
// 31 steps per digit, then the push state writes the remainder onto the stack.
// Popping passes through a read state and an emit state per digit. busy stays
// high until the final character is emitted, so a new transaction is not
// taken before the last one is through. Worst case is 31 digits, in base 2.
// Reset: arst_n clears the sequencer and the stack pointer at once; the stack
// memory itself needs no clearing, since every entry is pushed before it is
// popped.
module radix_convert_via_stack_unit #(
	parameter int STACK_DEPTH = 32
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  wire rcvs_pkg::item_t item,
	output logic            busy,
	output logic            result_valid,
	output rcvs_pkg::result_t result
);

	import rcvs_pkg::*;

	localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_PUSH = 5'b00100,
		ST_READ = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t              state_q;
	logic [NUMBER_W-1:0] value_q;   // dividend in, quotient out
	logic [BASE_W-1:0]   base_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [BITCNT_W-1:0] bit_cnt_q;
	logic [PTR_W-1:0]    sp_q;
	logic [DIGIT_W-1:0]  rd_q;

	logic [DIGIT_W-1:0]  stack_mem [STACK_DEPTH];

	logic                accept;
	logic [BASE_W-1:0]   base_clamped;
	logic [BASE_W-1:0]   trial;
	logic [BASE_W-1:0]   diff;
	logic                trial_ge;
	logic [DIGIT_W-1:0]  rem_next;
	logic [PTR_W-1:0]    sp_dec;
	logic                stack_full;

	assign accept = start && !busy;

	// Clamp the base into the supported range.
	always_comb begin
		if (item.base < BASE_MIN) begin
			base_clamped = BASE_MIN;
		end else if (item.base > BASE_MAX) begin
			base_clamped = BASE_MAX;
		end else begin
			base_clamped = item.base;
		end
	end

	// Shared divider step: shift one dividend bit into the partial remainder,
	// subtract the base when it fits. The remainder stays below the base, so
	// it fits in a digit after the subtraction; the shifted trial fits in 5 bits.
	assign trial    = {rem_q, value_q[NUMBER_W-1]};
	assign diff     = trial - base_q;
	assign trial_ge = (trial >= base_q);
	assign rem_next = trial_ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];

	assign sp_dec     = sp_q - PTR_W'(1);
	assign stack_full = (sp_q == PTR_W'(STACK_DEPTH));

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sp_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (item.number != '0)) begin
						sp_q    <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (bit_cnt_q == '0) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					// Drop the digit if the stack is full.
					if (!stack_full) begin
						sp_q <= sp_q + PTR_W'(1);
					end
					state_q <= (value_q == '0) ? ST_READ : ST_DIV;
				end
				ST_READ: begin
					sp_q    <= sp_dec;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					state_q <= (sp_q == '0) ? ST_IDLE : ST_READ;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: dividend, base, remainder and bit counter.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				value_q   <= item.number;
				base_q    <= base_clamped;
				rem_q     <= '0;
				bit_cnt_q <= BITCNT_W'(NUMBER_W - 1);
			end
			ST_DIV: begin
				value_q   <= {value_q[NUMBER_W-2:0], trial_ge};
				rem_q     <= rem_next;
				bit_cnt_q <= bit_cnt_q - BITCNT_W'(1);
			end
			ST_PUSH: begin
				// Restart the division on the quotient.
				rem_q     <= '0;
				bit_cnt_q <= BITCNT_W'(NUMBER_W - 1);
			end
			default: begin
			end
		endcase
	end

	// Digit stack: push the remainder, pop with a registered read.
	always_ff @(posedge clk) begin
		if ((state_q == ST_PUSH) && !stack_full) begin
			stack_mem[sp_q[ADDR_W-1:0]] <= rem_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q <= stack_mem[sp_dec[ADDR_W-1:0]];
		end
	end

	// Present the popped digit for one cycle; the last one empties the stack.
	assign busy                = (state_q != ST_IDLE);
	assign result_valid        = (state_q == ST_EMIT);
	assign result.digit_char   = digit_to_char(rd_q);
	assign result.last_digit   = (sp_q == '0);

`include "assert_macros.svh"

	`AST_ALWAYS(a_rem_below_base, !(state_q == ST_DIV) || ({1'b0, rem_q} < base_q),
		"partial remainder reached the base")
	`AST_ALWAYS(a_sp_in_range, sp_q <= PTR_W'(STACK_DEPTH),
		"stack pointer beyond stack depth")
	`AST_NEXT(a_last_ends_job, result_valid && result.last_digit, !busy,
		"block still busy after final digit")
	`AST_NEXT(a_nonzero_starts, start && !busy && (item.number != '0), busy,
		"nonzero transaction did not start conversion")

endmodule

`default_nettype wire
